// File: sv/vmlsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmlsl_pkg
// Shared types, constants and helpers of the voice mixer, one-pole lowpass
// and polynomial soft limiter.
// ----------------------------------------------------------------------------
package vmlsl_pkg;

   // voices and accumulator store
   localparam int VOICE_COUNT = 4;
   localparam int ACC_DEPTH   = 2 * VOICE_COUNT;
   localparam int ACC_AW      = $clog2(ACC_DEPTH);

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;
   localparam int ACC_W    = 32;
   localparam int AUDIO_W  = 24;
   localparam int SLOT_W   = 3;

   // mixer arithmetic
   localparam int MIX_PROD_W = SAMPLE_W + GAIN_W + 1;
   localparam int MIX_SUM_W  = MIX_PROD_W + 2;
   localparam int MIX_SHIFT  = 10;
   localparam int SAT_W      = 48;

   // lowpass arithmetic, coefficient 0.4 in Q0.16
   localparam int LP_DIFF_W = ACC_W + 1;
   localparam int LP_PROD_W = LP_DIFF_W + 17;
   localparam int LP_SHIFT  = 16;
   localparam int LP_COEF   = 26214;

   // limiter arithmetic (Q.24 magnitudes)
   localparam int POLY_STEPS   = 10;
   localparam int S_W          = 26;
   localparam int P_W          = 37;
   localparam int POLY_PROD_W  = 63;
   localparam int Q_SHIFT      = 24;
   localparam int RED_SHIFT    = 40;
   localparam int RED_W        = POLY_PROD_W - RED_SHIFT;
   localparam int Y_W          = 25;
   localparam int SCALE_PROD_W = 48;

   localparam logic [ACC_W-1:0] LIM_THRESH = 32'd13421772;
   localparam logic [ACC_W-1:0] LIM_THREE  = 32'd50331648;
   localparam logic [25:0]      LIM_D_MAG  = 26'd37633996;
   localparam logic [Y_W-1:0]   Q_ONE      = 25'd16777216;
   localparam logic [22:0]      FULL_SCALE = 23'd8388607;

   // result queue
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // item tag traveling down the pipeline
   typedef struct packed {
      logic       valid;
      logic [1:0] voice;
      logic       mode;
   } tag_type;

   // accumulator address of a tag: voice*2 + path
   function automatic logic [ACC_AW-1:0] acc_index(input tag_type t);
      logic [3:0] wide;
      wide = {1'b0, t.voice, t.mode};
      return wide[ACC_AW-1:0];
   endfunction

   // saturate to the signed 32-bit accumulator range
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(signed'({1'b0, {(ACC_W-1){1'b1}}}));
      lo = -hi - SAT_W'(1);
      if (x > hi) begin
         return {1'b0, {(ACC_W-1){1'b1}}};
      end else if (x < lo) begin
         return {1'b1, {(ACC_W-1){1'b0}}};
      end
      return x[ACC_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: sv/vmlsl_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmlsl_mix
// Weighted sum of four Q4.20 samples by four Q2.14 gains, floored to Q8.24
// and saturated. Two stages: products, then sum and saturate.
// ----------------------------------------------------------------------------
module vmlsl_mix
   import vmlsl_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tag_type                    in_tag,
   input  wire logic signed [SAMPLE_W-1:0] in_sample [4],
   input  wire logic        [GAIN_W-1:0]   in_gain [4],
   output      tag_type                    out_tag,
   output      logic signed [ACC_W-1:0]    out_mix
);

   logic signed [MIX_PROD_W-1:0] prod_in [4];
   logic signed [MIX_PROD_W-1:0] prod_ff [4];
   tag_type                      tag1_ff;
   logic signed [MIX_SUM_W-1:0]  sum_in;
   logic signed [ACC_W-1:0]      mix_in;
   logic signed [ACC_W-1:0]      mix_ff;
   tag_type                      tag2_ff;

   // four independent products
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = MIX_PROD_W'(in_sample[i]) * MIX_PROD_W'($signed({1'b0, in_gain[i]}));
      end
   end

   // sum, floor shift to Q8.24, saturate
   always_comb begin
      sum_in = MIX_SUM_W'(prod_ff[0]) + MIX_SUM_W'(prod_ff[1])
             + MIX_SUM_W'(prod_ff[2]) + MIX_SUM_W'(prod_ff[3]);
      mix_in = sat_acc(SAT_W'(sum_in >>> MIX_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      mix_ff  <= mix_in;
   end

   assign out_tag = tag2_ff;
   assign out_mix = mix_ff;

endmodule
`default_nettype wire

// File: sv/vmlsl_lowpass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmlsl_lowpass
// One-pole lowpass over the accumulator memory: a registered read, then update
// and write back, with a bypass of the write that lands on the same entry at
// the read edge.
// ----------------------------------------------------------------------------
module vmlsl_lowpass
   import vmlsl_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tag_type                 in_tag,
   input  wire logic signed [ACC_W-1:0] in_mix,
   output      tag_type                 out_tag,
   output      logic signed [ACC_W-1:0] out_acc
);

   // accumulator store; entries not yet written read as zero
   logic signed [ACC_W-1:0] acc_mem [ACC_DEPTH];
   logic [ACC_DEPTH-1:0]    written_ff;

   logic [ACC_AW-1:0]       rd_addr;
   logic signed [ACC_W-1:0] rd_data_ff;
   logic                    rd_written_ff;
   logic                    fwd_ff;
   logic signed [ACC_W-1:0] fwd_data_ff;
   logic signed [ACC_W-1:0] mix_ff;
   tag_type                 tag_b_ff;

   logic                    wr_en;
   logic [ACC_AW-1:0]       wr_addr;
   logic signed [ACC_W-1:0] acc_old;
   logic signed [LP_DIFF_W-1:0] diff;
   logic signed [LP_PROD_W-1:0] prod;
   logic signed [LP_PROD_W-1:0] delta;
   logic signed [SAT_W-1:0]     sum;
   logic signed [ACC_W-1:0]     acc_in;
   logic signed [ACC_W-1:0]     acc_ff;
   tag_type                     tag_o_ff;

   assign rd_addr = acc_index(in_tag);
   assign wr_en   = tag_b_ff.valid;
   assign wr_addr = acc_index(tag_b_ff);

   // update: acc += floor((mix - acc) * 0.4), saturated
   always_comb begin
      if (fwd_ff) begin
         acc_old = fwd_data_ff;
      end else if (rd_written_ff) begin
         acc_old = rd_data_ff;
      end else begin
         acc_old = '0;
      end
      diff   = LP_DIFF_W'(mix_ff) - LP_DIFF_W'(acc_old);
      prod   = LP_PROD_W'(diff) * LP_PROD_W'(LP_COEF);
      delta  = prod >>> LP_SHIFT;
      sum    = SAT_W'(acc_old) + SAT_W'(delta);
      acc_in = sat_acc(sum);
   end

   // memory read and write ports
   always_ff @(posedge clock) begin
      rd_data_ff <= acc_mem[rd_addr];
      if (wr_en) begin
         acc_mem[wr_addr] <= acc_in;
      end
   end

   // written flags, forward flag and tags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
         fwd_ff        <= 1'b0;
         tag_b_ff      <= '0;
         tag_o_ff      <= '0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_written_ff <= written_ff[rd_addr];
         fwd_ff        <= wr_en && (wr_addr == rd_addr);
         tag_b_ff      <= in_tag;
         tag_o_ff      <= tag_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= acc_in;
      mix_ff      <= in_mix;
      acc_ff      <= acc_in;
   end

   assign out_tag = tag_o_ff;
   assign out_acc = acc_ff;

endmodule
`default_nettype wire

// File: sv/vmlsl_limiter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmlsl_limiter
// Pipelined soft limiter: magnitude, range split, ten stages of the power
// (3-|x|)^11, reduction by |d|, then negate and scale to the 24-bit word.
// ----------------------------------------------------------------------------
module vmlsl_limiter
   import vmlsl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tag_type                   in_tag,
   input  wire logic signed [ACC_W-1:0]   in_acc,
   output      tag_type                   out_tag,
   output      logic signed [AUDIO_W-1:0] out_audio
);

   typedef struct packed {
      tag_type     tag;
      logic        neg;
      logic        pass;
      logic        full;
      logic [23:0] pmag;
   } lim_ctl_type;

   // magnitude stage
   tag_type            l0_tag_ff;
   logic               l0_neg_ff;
   logic [ACC_W-1:0]   l0_mag_ff;
   logic [ACC_W-1:0]   s_wide;

   // power stages
   lim_ctl_type        ctl_ff [POLY_STEPS+1];
   logic [P_W-1:0]     p_ff [POLY_STEPS+1];
   logic [S_W-1:0]     s_ff [POLY_STEPS+1];
   logic [POLY_PROD_W-1:0] pp [POLY_STEPS];

   // reduction, magnitude and output stages
   logic [POLY_PROD_W-1:0]  red_prod;
   logic [RED_W-1:0]        red_ff;
   lim_ctl_type             ctl_r_ff;
   logic [Y_W-1:0]          y_in;
   logic [Y_W-1:0]          y_ff;
   lim_ctl_type             ctl_y_ff;
   logic [SCALE_PROD_W-1:0] scale_prod;
   logic [AUDIO_W-1:0]      scaled;
   logic signed [AUDIO_W-1:0] audio_ff;
   tag_type                 tag_o_ff;

   assign s_wide = LIM_THREE - l0_mag_ff;

   always_comb begin
      for (int k = 0; k < POLY_STEPS; k++) begin
         pp[k] = POLY_PROD_W'(p_ff[k]) * POLY_PROD_W'(s_ff[k]);
      end
   end

   // reduction stays below 2^24 for every s in range, so no floor at zero
   assign red_prod = POLY_PROD_W'(LIM_D_MAG) * POLY_PROD_W'(p_ff[POLY_STEPS]);

   always_comb begin
      if (ctl_r_ff.pass) begin
         y_in = {1'b0, ctl_r_ff.pmag};
      end else if (ctl_r_ff.full) begin
         y_in = Q_ONE;
      end else begin
         y_in = Q_ONE - Y_W'(red_ff);
      end
   end

   assign scale_prod = SCALE_PROD_W'(y_ff) * SCALE_PROD_W'(FULL_SCALE);
   assign scaled     = scale_prod[Q_SHIFT +: AUDIO_W];

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         l0_tag_ff <= '0;
         for (int k = 0; k <= POLY_STEPS; k++) begin
            ctl_ff[k] <= '0;
         end
         ctl_r_ff <= '0;
         ctl_y_ff <= '0;
         tag_o_ff <= '0;
      end else begin
         l0_tag_ff        <= in_tag;
         ctl_ff[0].tag    <= l0_tag_ff;
         ctl_ff[0].neg    <= l0_neg_ff;
         ctl_ff[0].pass   <= (l0_mag_ff <= LIM_THRESH);
         ctl_ff[0].full   <= (l0_mag_ff >= LIM_THREE);
         ctl_ff[0].pmag   <= l0_mag_ff[23:0];
         for (int k = 1; k <= POLY_STEPS; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
         ctl_r_ff <= ctl_ff[POLY_STEPS];
         ctl_y_ff <= ctl_r_ff;
         tag_o_ff <= ctl_y_ff.tag;
      end
   end

   // datapath pipeline
   always_ff @(posedge clock) begin
      l0_neg_ff <= in_acc[ACC_W-1];
      l0_mag_ff <= in_acc[ACC_W-1] ? (ACC_W'(0) - in_acc) : in_acc;
      p_ff[0]   <= P_W'(s_wide[S_W-1:0]);
      s_ff[0]   <= s_wide[S_W-1:0];
      for (int k = 1; k <= POLY_STEPS; k++) begin
         p_ff[k] <= pp[k-1][Q_SHIFT +: P_W];
         s_ff[k] <= s_ff[k-1];
      end
      red_ff   <= red_prod[RED_SHIFT +: RED_W];
      y_ff     <= y_in;
      audio_ff <= ctl_y_ff.neg ? scaled : (AUDIO_W'(0) - scaled);
   end

   assign out_tag   = tag_o_ff;
   assign out_audio = audio_ff;

endmodule
`default_nettype wire

// File: sv/vmlsl_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmlsl_out_fifo
// Result queue with credit count: a credit is taken at each accepted item
// that will make a result and returned when the result leaves, so the
// pipeline never has to stall.
// ----------------------------------------------------------------------------
module vmlsl_out_fifo
   import vmlsl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      take_credit,
   output      logic                      has_room,
   input  wire logic                      push,
   input  wire logic [SLOT_W-1:0]         push_slot,
   input  wire logic signed [AUDIO_W-1:0] push_audio,
   output      logic                      pop_valid,
   input  wire logic                      pop_ready,
   output      logic [SLOT_W-1:0]         pop_slot,
   output      logic signed [AUDIO_W-1:0] pop_audio
);

   logic [SLOT_W+AUDIO_W-1:0] entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]        wr_ptr_ff;
   logic [FIFO_AW-1:0]        rd_ptr_ff;
   logic [FIFO_AW:0]          count_ff;
   logic [FIFO_AW:0]          credit_ff;
   logic                      pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != '0);
   assign has_room  = (credit_ff < (FIFO_AW+1)'(FIFO_DEPTH));
   assign {pop_slot, pop_audio} = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {push_slot, push_audio};
      end
   end

   // pointers, fill count and credits
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff  <= count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
         credit_ff <= credit_ff + (FIFO_AW+1)'(take_credit) - (FIFO_AW+1)'(pop);
      end
   end

endmodule
`default_nettype wire

// File: sv/voice_mixer_lowpass_soft_limiter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voice_mixer_lowpass_soft_limiter_core
// Per-voice, per-path mixer, one-pole lowpass and polynomial soft limiter.
// ----------------------------------------------------------------------------
// Path: a result is offered after its transaction has passed the mixer,
// the accumulator read/update, the limiter and the result queue registers.
// Throughput: one transaction per cycle; the 32-entry result queue holds
// everything in flight, so req_tready drops only when results are not taken.
// Reset: synchronous; all accumulators read as zero right after reset through
// per-entry written flags, and the result queue is empty.
module voice_mixer_lowpass_soft_limiter_core
   import vmlsl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // noise_sample, osc_a_sample, osc_b_sample, sub_sample (24 each),
   // noise_gain, osc_a_gain, osc_b_gain, sub_gain (16 each)
   input  wire logic [159:0] req_tdata,
   // voice (2), mode (1)
   input  wire logic [2:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // audio_word (24)
   output      logic [23:0]  rsp_tdata,
   // channel_slot (3)
   output      logic [2:0]   rsp_tuser
);

   tag_type                   in_tag;
   logic signed [SAMPLE_W-1:0] sample [4];
   logic        [GAIN_W-1:0]   gain [4];
   logic                      accept;

   tag_type                   mix_tag;
   logic signed [ACC_W-1:0]   mix;
   tag_type                   lp_tag;
   logic signed [ACC_W-1:0]   acc;
   tag_type                   lim_tag;
   logic signed [AUDIO_W-1:0] lim_audio;
   logic signed [AUDIO_W-1:0] rsp_audio;

   // unpack the transaction; voices beyond the count make no result
   assign accept       = req_tvalid && req_tready;
   assign in_tag.voice = req_tuser[1:0];
   assign in_tag.mode  = req_tuser[2];
   assign in_tag.valid = accept && ({2'b00, req_tuser[1:0]} < 4'(VOICE_COUNT));

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sample[i] = req_tdata[i*SAMPLE_W +: SAMPLE_W];
         gain[i]   = req_tdata[4*SAMPLE_W + i*GAIN_W +: GAIN_W];
      end
   end

   vmlsl_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (in_tag),
      .in_sample (sample),
      .in_gain   (gain),
      .out_tag   (mix_tag),
      .out_mix   (mix)
   );

   vmlsl_lowpass u_lowpass (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (mix_tag),
      .in_mix  (mix),
      .out_tag (lp_tag),
      .out_acc (acc)
   );

   vmlsl_limiter u_limiter (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (lp_tag),
      .in_acc    (acc),
      .out_tag   (lim_tag),
      .out_audio (lim_audio)
   );

   // output slot: voices swapped within each pair (voice XOR 1), path in the low bit
   vmlsl_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .take_credit (in_tag.valid),
      .has_room    (req_tready),
      .push        (lim_tag.valid),
      .push_slot   ({lim_tag.voice ^ 2'b01, lim_tag.mode}),
      .push_audio  (lim_audio),
      .pop_valid   (rsp_tvalid),
      .pop_ready   (rsp_tready),
      .pop_slot    (rsp_tuser),
      .pop_audio   (rsp_audio)
   );

   assign rsp_tdata = rsp_audio;

endmodule
`default_nettype wire
